// ===== hdl/dps_pkg.sv =====
// Shared types and constants of the dynamic priority scheduler.
`default_nettype none
package dps_pkg;

  localparam int NUM_SLOTS_DEF = 8;

  localparam int CMD_W   = 1;
  localparam int SLOT_W  = 3;
  localparam int NEED_W  = 8;
  localparam int PRIO_W  = 13;
  localparam int CPU_W   = 8;
  localparam int STEP_W  = 4;
  localparam int ENTRY_W = NEED_W + PRIO_W + CPU_W;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  localparam logic [STEP_W-1:0] STEP_RESET = 4'd3;

  localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
  localparam logic [CMD_W-1:0] CMD_TICK = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic load_wr;
    logic scan_rd;
    logic upd;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== hdl/dynamic_priority_scheduler_top.sv =====
// Top level of the dynamic priority scheduler.
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tdata {need_time, slot}, tuser cmd
// m_*      out  m_tvalid/m_tready  tdata {all_done, run_total, remaining, ran, chosen_slot}
// cfg_*    in   cfg_we             cfg_wdata priority_step
//
// One transaction at a time. A load writes the table entry; a tick scans the table RAM,
// one slot per cycle, then drains and updates. Both then load the output register.
// Synchronous reset clears the table at once through per-slot valid bits; no clearing pass.
// A stalled result holds in the output register; the next transaction is accepted once
// the previous result has entered that register.
`default_nettype none
module dynamic_priority_scheduler_top #(
  parameter int NUM_SLOTS = dps_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [dps_pkg::IN_DATA_W-1:0]     s_tdata,  // slot[2:0], need_time[10:3]
  input  wire logic [dps_pkg::CMD_W-1:0]         s_tuser,  // cmd[0]
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [dps_pkg::OUT_DATA_W-1:0]         m_tdata,  // chosen_slot[2:0], ran[3],
                                                           // remaining[11:4], run_total[19:12],
                                                           // all_done[20]
  input  wire logic                              cfg_we,
  input  wire logic [dps_pkg::STEP_W-1:0]        cfg_wdata
);

  dps_pkg::dp_cmd_t  cmd;
  dps_pkg::dp_stat_t stat;

  dps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .in_cmd   (s_tuser),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dps_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_slot   (s_tdata[dps_pkg::SLOT_W-1:0]),
    .in_need   (s_tdata[dps_pkg::SLOT_W +: dps_pkg::NEED_W]),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
`default_nettype wire

// ===== hdl/dps_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module dps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/dps_ctrl.sv =====
// Sequencer of the dynamic priority scheduler.
`default_nettype none
module dps_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  input  wire logic [dps_pkg::CMD_W-1:0]   in_cmd,
  output logic                             s_tready,
  input  wire dps_pkg::dp_stat_t           stat,
  output dps_pkg::dp_cmd_t                 cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_UPD   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        cmd.capture = s_tvalid;
        if (s_tvalid) begin
          state_next = (in_cmd == dps_pkg::CMD_LOAD) ? S_LOAD : S_SCAN;
        end
      end
      S_LOAD: begin
        cmd.load_wr = 1'b1;
        state_next  = S_OUT;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        cmd.out_load = stat.out_free;
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/dps_datapath.sv =====
// Slot table, priority scan, slot update and output register.
`default_nettype none
module dps_datapath #(
  parameter int NUM_SLOTS = dps_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire dps_pkg::dp_cmd_t                 cmd,
  output dps_pkg::dp_stat_t                     stat,
  input  wire logic [dps_pkg::SLOT_W-1:0]       in_slot,
  input  wire logic [dps_pkg::NEED_W-1:0]       in_need,
  input  wire logic                             cfg_we,
  input  wire logic [dps_pkg::STEP_W-1:0]       cfg_wdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [dps_pkg::OUT_DATA_W-1:0]        m_tdata
);

  localparam int SW = $clog2(NUM_SLOTS);
  localparam int NW = dps_pkg::NEED_W;
  localparam int PW = dps_pkg::PRIO_W;
  localparam int CW = dps_pkg::CPU_W;
  localparam int EW = dps_pkg::ENTRY_W;

  logic [dps_pkg::STEP_W-1:0] priority_step;

  logic [dps_pkg::SLOT_W-1:0] cap_slot;
  logic [NW-1:0]              cap_need;

  logic [NUM_SLOTS-1:0] valid;
  logic [NUM_SLOTS-1:0] nz;

  logic [SW-1:0] scan_idx;
  logic          cmp_v;
  logic [SW-1:0] cmp_idx;
  logic          rd_vld;

  logic          ram_we;
  logic [SW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;
  logic [EW-1:0] rd_entry;

  logic [NW-1:0] rd_need;
  logic [PW-1:0] rd_prio;
  logic [CW-1:0] rd_cpu;
  logic          rd_qual;

  logic [SW-1:0] best_idx;
  logic          best_q;
  logic [NW-1:0] best_need;
  logic [PW-1:0] best_prio;
  logic [CW-1:0] best_cpu;

  logic          load_ok;
  logic [SW-1:0] load_addr;
  logic          best_runs;
  logic [NW-1:0] upd_need;
  logic [PW-1:0] upd_prio;
  logic [CW-1:0] upd_cpu;

  logic [dps_pkg::SLOT_W-1:0] res_chosen;
  logic                       res_ran;
  logic [NW-1:0]              res_remaining;
  logic [CW-1:0]              res_run;

  assign load_ok   = int'(cap_slot) < NUM_SLOTS;
  assign load_addr = SW'(cap_slot);
  assign best_runs = (best_need != '0);
  assign upd_need  = best_need - NW'(1);
  assign upd_prio  = best_prio - PW'(priority_step);
  assign upd_cpu   = best_cpu + CW'(1);

  assign stat = '{scan_last: (scan_idx == SW'(NUM_SLOTS - 1)),
                  out_free:  (!m_tvalid || m_tready)};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = best_idx;
    ram_wdata = {upd_need, upd_prio, upd_cpu};
    if (cmd.load_wr) begin
      ram_we    = load_ok;
      ram_waddr = load_addr;
      ram_wdata = {cap_need, PW'(cap_need), CW'(0)};
    end else if (cmd.upd) begin
      ram_we = best_runs;
    end
  end

  dps_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_idx),
    .rdata (ram_rdata)
  );

  // an entry never written reads as zero
  assign rd_entry = rd_vld ? ram_rdata : '0;
  assign rd_need  = rd_entry[EW-1 -: NW];
  assign rd_prio  = rd_entry[CW +: PW];
  assign rd_cpu   = rd_entry[CW-1:0];
  assign rd_qual  = (rd_need != '0) && ($signed(rd_prio) > $signed(PW'(0)));

  always_ff @(posedge clk) begin
    if (rst) begin
      priority_step <= dps_pkg::STEP_RESET;
    end else if (cfg_we) begin
      priority_step <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_slot <= in_slot;
      cap_need <= in_need;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      nz    <= '0;
    end else if (ram_we) begin
      valid[ram_waddr] <= 1'b1;
      nz[ram_waddr]    <= cmd.load_wr ? (cap_need != '0) : (upd_need != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      cmp_v    <= 1'b0;
    end else begin
      cmp_v <= cmd.scan_rd;
      if (cmd.capture) begin
        scan_idx <= '0;
      end else if (cmd.scan_rd && !stat.scan_last) begin
        scan_idx <= scan_idx + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx;
    rd_vld  <= valid[scan_idx];
  end

  // slot 0 is the fallback and keeps its own priority; a qualifying slot replaces it
  // when slot 0 does not qualify, otherwise only on a strictly greater priority
  always_ff @(posedge clk) begin
    if (cmp_v) begin
      if (cmp_idx == '0) begin
        best_idx  <= '0;
        best_q    <= rd_qual;
        best_need <= rd_need;
        best_cpu  <= rd_cpu;
        best_prio <= rd_prio;
      end else if (rd_qual && (!best_q || ($signed(rd_prio) > $signed(best_prio)))) begin
        best_idx  <= cmp_idx;
        best_q    <= 1'b1;
        best_need <= rd_need;
        best_cpu  <= rd_cpu;
        best_prio <= rd_prio;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      res_chosen    <= cap_slot;
      res_ran       <= 1'b0;
      res_remaining <= load_ok ? cap_need : '0;
      res_run       <= '0;
    end else if (cmd.upd) begin
      res_chosen    <= dps_pkg::SLOT_W'(best_idx);
      res_ran       <= best_runs;
      res_remaining <= best_runs ? upd_need : best_need;
      res_run       <= best_runs ? upd_cpu : best_cpu;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {3'b000, !(|nz), res_run, res_remaining, res_ran, res_chosen};
    end
  end

endmodule
`default_nettype wire

// ===== hdl/dps_checker.sv =====
// Port-level checks of the dynamic priority scheduler, bound to the top level.
`default_nettype none
module dps_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tvalid,
  input wire logic                          s_tready,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [dps_pkg::OUT_DATA_W-1:0] m_tdata
);

  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one transaction in flight
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while busy");

  // a result never appears right after an acceptance
  a_lat: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
    else $error("result too early");

  // a slot that ran has a nonzero run count
  a_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |-> m_tdata[19:12] != 8'd0)
    else $error("ran with zero run total");

  // all done means the chosen slot has nothing left
  a_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[20] |-> m_tdata[11:4] == 8'd0)
    else $error("all done with time remaining");

endmodule

bind dynamic_priority_scheduler_top dps_checker u_dps_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
